// ===== rtl/adc_level_quantizer_debounce_core_defines.svh =====
// ----------------------------------------------------------------------------
// adc level quantizer debounce core - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ADC_LEVEL_QUANTIZER_DEBOUNCE_CORE_DEFINES_SVH
`define ADC_LEVEL_QUANTIZER_DEBOUNCE_CORE_DEFINES_SVH

// same-cycle implication
`define ALQD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/alqd_pkg.sv =====
// ----------------------------------------------------------------------------
// alqd_pkg
// shared widths, defaults, register map and config types
// ----------------------------------------------------------------------------
package alqd_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 7;
  localparam int MARGIN_W   = 6;
  localparam int LIMIT_W    = 4;
  localparam int FULL_SCALE = 4095;

  localparam int AVG_DEPTH_DEF   = 8;
  localparam int LEVEL_COUNT_DEF = 85;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic                RST_USE_HAND = 1'b0;
  localparam logic [MARGIN_W-1:0] RST_MARGIN   = MARGIN_W'(15);
  localparam logic [LIMIT_W-1:0]  RST_LIMIT    = LIMIT_W'(3);

  typedef enum logic [1:0] {
    REG_USE_HAND       = 2'd0,
    REG_ROUND_MARGIN   = 2'd1,
    REG_DEBOUNCE_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                use_hand_channel;
    logic [MARGIN_W-1:0] round_margin;
    logic [LIMIT_W-1:0]  debounce_limit;
  } cfg_t;

endpackage

// ===== rtl/alqd_if.sv =====
// ----------------------------------------------------------------------------
// alqd_if
// valid/ready channels for sample transactions and level results
// ----------------------------------------------------------------------------
interface alqd_in_if import alqd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_hand;
  logic [SAMPLE_W-1:0] sample_foot;

  modport source (output valid, output sample_hand, output sample_foot, input ready);
  modport sink (input valid, input sample_hand, input sample_foot, output ready);
endinterface

interface alqd_out_if import alqd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average_value;
  logic [LEVEL_W-1:0]  raw_level;
  logic [LEVEL_W-1:0]  settled_level;

  modport source (output valid, output average_value, output raw_level,
                  output settled_level, input ready);
  modport sink (input valid, input average_value, input raw_level,
                input settled_level, output ready);
endinterface

// ===== rtl/alqd_cdiv.sv =====
// ----------------------------------------------------------------------------
// alqd_cdiv
// divide by a constant through a reciprocal multiply, exact over the input range
// ----------------------------------------------------------------------------
module alqd_cdiv #(
  parameter int DIVISOR = 1,
  parameter int IN_W    = 8,
  parameter int OUT_W   = 8
) (
  input  logic [IN_W-1:0]  dividend,
  output logic [OUT_W-1:0] quotient
);

  localparam int SHIFT = IN_W + $clog2(DIVISOR);
  localparam int M_W   = IN_W + 2;
  localparam int P_W   = (IN_W + M_W > SHIFT + OUT_W) ? (IN_W + M_W) : (SHIFT + OUT_W);
  localparam logic [P_W-1:0] RECIP =
    P_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [P_W-1:0] prod;

  assign prod     = P_W'(dividend) * RECIP;
  assign quotient = prod[SHIFT +: OUT_W];

endmodule

// ===== rtl/alqd_cfg.sv =====
// ----------------------------------------------------------------------------
// alqd_cfg
// apb register file: channel select, round margin, debounce limit
// also keeps the margin threshold prescaled to the running-sum domain
// ----------------------------------------------------------------------------
module alqd_cfg import alqd_pkg::*; #(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF,
  parameter int THR_W     = $clog2(AVG_DEPTH) + MARGIN_W + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg,
  output logic [THR_W-1:0]      margin_thr
);

  localparam logic [THR_W-1:0] DEPTH_C = THR_W'(AVG_DEPTH);
  localparam logic [THR_W-1:0] THR_RST = THR_W'(AVG_DEPTH * (int'(RST_MARGIN) + 1));

  cfg_t             cfg_r, cfg_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    thr_nxt = thr_r;
    if (wr_en) begin
      unique case (idx)
        REG_USE_HAND: begin
          cfg_nxt.use_hand_channel = pwdata[0];
        end
        REG_ROUND_MARGIN: begin
          cfg_nxt.round_margin = pwdata[MARGIN_W-1:0];
          thr_nxt = DEPTH_C * (THR_W'(pwdata[MARGIN_W-1:0]) + THR_W'(1));
        end
        REG_DEBOUNCE_LIMIT: begin
          cfg_nxt.debounce_limit = pwdata[LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_hand_channel <= RST_USE_HAND;
      cfg_r.round_margin     <= RST_MARGIN;
      cfg_r.debounce_limit   <= RST_LIMIT;
      thr_r                  <= THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
      thr_r <= thr_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_USE_HAND:       prdata = APB_DATA_W'(cfg_r.use_hand_channel);
      REG_ROUND_MARGIN:   prdata = APB_DATA_W'(cfg_r.round_margin);
      REG_DEBOUNCE_LIMIT: prdata = APB_DATA_W'(cfg_r.debounce_limit);
      default:            prdata = '0;
    endcase
  end

  assign cfg        = cfg_r;
  assign margin_thr = thr_r;

endmodule

// ===== rtl/alqd_window.sv =====
// ----------------------------------------------------------------------------
// alqd_window
// moving-average window: sample shift line, fill count and running sum
// ----------------------------------------------------------------------------
module alqd_window import alqd_pkg::*; #(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF,
  parameter int SUM_W     = SAMPLE_W + $clog2(AVG_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SUM_W-1:0]    sum_new
);

  localparam int CNT_W = $clog2(AVG_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(AVG_DEPTH);

  logic [SAMPLE_W-1:0] win_r [AVG_DEPTH];
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] oldest;

  // taps not yet filled since reset count as zero
  assign oldest  = (cnt_r == FULL_C) ? win_r[AVG_DEPTH-1] : '0;
  assign sum_new = sum_r - SUM_W'(oldest) + SUM_W'(sample);
  assign cnt_nxt = (cnt_r == FULL_C) ? cnt_r : cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      win_r[0] <= sample;
      for (int i = 1; i < AVG_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

endmodule

// ===== rtl/alqd_level.sv =====
// ----------------------------------------------------------------------------
// alqd_level
// average and quantized level straight from the running sum
// ----------------------------------------------------------------------------
module alqd_level import alqd_pkg::*; #(
  parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
  parameter int SUM_W       = SAMPLE_W + $clog2(AVG_DEPTH),
  parameter int THR_W       = $clog2(AVG_DEPTH) + MARGIN_W + 1
) (
  input  logic [SUM_W-1:0]    sum,
  input  logic [THR_W-1:0]    margin_thr,
  output logic [SAMPLE_W-1:0] avg,
  output logic [LEVEL_W-1:0]  raw_level
);

  localparam int STEP  = FULL_SCALE / (LEVEL_COUNT - 1);
  localparam int DIV_L = AVG_DEPTH * STEP;
  localparam int Q_W   = LEVEL_W + 1;
  localparam logic [Q_W-1:0] TOP_C = Q_W'(LEVEL_COUNT - 1);

  logic [Q_W-1:0]   q_lvl;
  logic [Q_W-1:0]   q_bump;
  logic [SUM_W-1:0] thr_ext;
  logic [SUM_W-1:0] sum_less;
  logic             above_thr;
  logic             bump;

  // remainder above margin <=> (sum - depth*(margin+1)) / (depth*step) reaches the level
  assign thr_ext   = SUM_W'(margin_thr);
  assign above_thr = (sum >= thr_ext);
  assign sum_less  = above_thr ? (sum - thr_ext) : '0;

  alqd_cdiv #(.DIVISOR(AVG_DEPTH), .IN_W(SUM_W), .OUT_W(SAMPLE_W)) u_avg_div (
    .dividend (sum),
    .quotient (avg)
  );

  alqd_cdiv #(.DIVISOR(DIV_L), .IN_W(SUM_W), .OUT_W(Q_W)) u_lvl_div (
    .dividend (sum),
    .quotient (q_lvl)
  );

  alqd_cdiv #(.DIVISOR(DIV_L), .IN_W(SUM_W), .OUT_W(Q_W)) u_bump_div (
    .dividend (sum_less),
    .quotient (q_bump)
  );

  assign bump = above_thr && (q_bump >= q_lvl);

  always_comb begin
    if (q_lvl >= TOP_C) begin
      raw_level = TOP_C[LEVEL_W-1:0];
    end else begin
      raw_level = q_lvl[LEVEL_W-1:0] + LEVEL_W'(bump);
    end
  end

endmodule

// ===== rtl/alqd_debounce.sv =====
// ----------------------------------------------------------------------------
// alqd_debounce
// repeat counter that promotes a raw level to the stable level
// ----------------------------------------------------------------------------
module alqd_debounce import alqd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [LEVEL_W-1:0] raw_level,
  input  logic [LIMIT_W-1:0] debounce_limit,
  output logic [LEVEL_W-1:0] settled_level
);

  logic [LEVEL_W-1:0] prev_r, prev_nxt;
  logic [LIMIT_W-1:0] rep_r, rep_nxt;
  logic [LEVEL_W-1:0] held_r, held_nxt;

  always_comb begin
    prev_nxt = prev_r;
    rep_nxt  = rep_r;
    held_nxt = held_r;
    priority if (raw_level != prev_r) begin
      prev_nxt = raw_level;
      rep_nxt  = '0;
    end else if (rep_r < debounce_limit) begin
      rep_nxt = rep_r + LIMIT_W'(1);
    end else begin
      held_nxt = raw_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      rep_r  <= '0;
      held_r <= '0;
    end else if (push) begin
      prev_r <= prev_nxt;
      rep_r  <= rep_nxt;
      held_r <= held_nxt;
    end
  end

  assign settled_level = held_nxt;

endmodule

// ===== rtl/adc_level_quantizer_debounce_core.sv =====
// ----------------------------------------------------------------------------
// adc_level_quantizer_debounce_core
// sample select, moving average, level quantizer and debounce, unless stalled, one transaction a cycle
// ----------------------------------------------------------------------------
// Takes one hand/foot sample pair per transaction and returns one result per
// transaction: the moving average of the last AVG_DEPTH selected samples, its
// quantized level and the debounced level. A new transaction is accepted every
// cycle while the output is not stalled; each one passes an input register and a
// result register, and its result is presented from the result register after
// the input register, once the output is not stalled. The rate is set by the
// running-sum update in the window. The window reads as zero after reset until
// it has been filled once. The user must write configuration through the apb
// port while no transaction is in flight; the block does not enforce this.
`include "adc_level_quantizer_debounce_core_defines.svh"

module adc_level_quantizer_debounce_core import alqd_pkg::*; #(
  parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  alqd_in_if.sink               in_ch,
  alqd_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SUM_W = SAMPLE_W + $clog2(AVG_DEPTH);
  localparam int THR_W = $clog2(AVG_DEPTH) + MARGIN_W + 1;
  localparam logic [LEVEL_W-1:0] TOP_LVL = LEVEL_W'(LEVEL_COUNT - 1);

  cfg_t                cfg;
  logic [THR_W-1:0]    margin_thr;

  logic                smp_v_r, smp_v_nxt;
  logic [SAMPLE_W-1:0] smp_r;
  logic                out_v_r, out_v_nxt;
  logic [SAMPLE_W-1:0] avg_r;
  logic [LEVEL_W-1:0]  raw_r;
  logic [LEVEL_W-1:0]  stable_r;

  logic                in_acc;
  logic                adv;
  logic                out_stall;
  logic [SUM_W-1:0]    sum_new;
  logic [SAMPLE_W-1:0] avg_c;
  logic [LEVEL_W-1:0]  raw_c;
  logic [LEVEL_W-1:0]  stable_c;

  alqd_cfg #(.AVG_DEPTH(AVG_DEPTH), .THR_W(THR_W)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .margin_thr (margin_thr)
  );

  // handshake: the result register parts input and output sides
  assign adv          = smp_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !smp_v_r || !out_v_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign smp_v_nxt    = in_acc || (smp_v_r && !adv);
  assign out_v_nxt    = adv || (out_v_r && !out_ch.ready);
  assign out_stall    = out_v_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      smp_v_r <= smp_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= cfg.use_hand_channel ? in_ch.sample_hand : in_ch.sample_foot;
    end
  end

  alqd_window #(.AVG_DEPTH(AVG_DEPTH), .SUM_W(SUM_W)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (adv),
    .sample  (smp_r),
    .sum_new (sum_new)
  );

  alqd_level #(
    .AVG_DEPTH   (AVG_DEPTH),
    .LEVEL_COUNT (LEVEL_COUNT),
    .SUM_W       (SUM_W),
    .THR_W       (THR_W)
  ) u_level (
    .sum        (sum_new),
    .margin_thr (margin_thr),
    .avg        (avg_c),
    .raw_level  (raw_c)
  );

  alqd_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (adv),
    .raw_level      (raw_c),
    .debounce_limit (cfg.debounce_limit),
    .settled_level  (stable_c)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      avg_r    <= avg_c;
      raw_r    <= raw_c;
      stable_r <= stable_c;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.average_value = avg_r;
  assign out_ch.raw_level     = raw_r;
  assign out_ch.settled_level = stable_r;

  `ALQD_ASSERT_IMP(a_stall_blocks_input, out_stall && smp_v_r, !in_ch.ready, "input taken in stall")
  `ALQD_ASSERT_NEXT(a_adv_gives_result, adv, out_v_r, "advanced transaction lost")
  `ALQD_ASSERT_NEXT(a_result_held, out_stall, $stable({avg_r, raw_r, stable_r}), "result moved")
  `ALQD_ASSERT_IMP(a_lvl_range, out_v_r, raw_r <= TOP_LVL && stable_r <= TOP_LVL, "level too high")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the level quantizer core against an in-bench predictor of the
// moving average, quantizer and debounce; a short table of directed samples,
// then shaped random phases under several register settings, with random
// idling on both channels and one long result hold-off
// ----------------------------------------------------------------------------
module tb_top;
  import alqd_pkg::*;

  localparam int CLK_PERIOD    = 2;
  localparam int RESET_CYCLES  = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_ITEMS   = 280;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_IDLE      = 8;
  localparam int LEVEL_STEP    = FULL_SCALE / (LEVEL_COUNT_DEF - 1);
  localparam int TOP_LEVEL     = LEVEL_COUNT_DEF - 1;

  // first address past the register map
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(12);

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_value;
    logic [LEVEL_W-1:0]  raw_level;
    logic [LEVEL_W-1:0]  settled_level;
  } level_result_t;

  typedef struct packed {
    logic                typed;
    logic [SAMPLE_W-1:0] hand;
    logic [SAMPLE_W-1:0] foot;
    level_result_t       result;
  } sample_row_t;

  typedef enum int {SHAPE_NOISE, SHAPE_HOLD, SHAPE_RAIL, SHAPE_EDGE} shape_t;

  localparam level_result_t ZERO_RESULT = '0;
  localparam int DIRECTED_ROWS = 20;
  localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, 12'd4095, 12'd0,    ZERO_RESULT},
    '{1'b1, 12'hAAA,  12'd0,    ZERO_RESULT},
    '{1'b1, 12'h555,  12'd0,    ZERO_RESULT},
    '{1'b1, 12'd0,    12'd0,    ZERO_RESULT},
    '{1'b0, 12'd0,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd4095, 12'd4095, ZERO_RESULT},
    '{1'b0, 12'h0F0,  12'd4095, ZERO_RESULT},
    '{1'b0, 12'hF0F,  12'd4095, ZERO_RESULT},
    '{1'b0, 12'd1,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd2048, 12'd4095, ZERO_RESULT},
    '{1'b0, 12'd0,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd0,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd0,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd0,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd0,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd0,    12'd4095, ZERO_RESULT},
    '{1'b0, 12'd0,    12'h800,  ZERO_RESULT},
    '{1'b0, 12'd0,    12'h7FF,  ZERO_RESULT},
    '{1'b0, 12'd0,    12'd1,    ZERO_RESULT},
    '{1'b0, 12'd0,    12'd63,   ZERO_RESULT}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  alqd_in_if  in_bus ();
  alqd_out_if out_bus ();

  adc_level_quantizer_debounce_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state
  cfg_t        level_cfg;
  int unsigned sample_hist [AVG_DEPTH_DEF];
  int unsigned hist_sum;
  int unsigned hist_slot;
  int unsigned last_raw;
  int unsigned repeat_run;
  int unsigned held_level;

  level_result_t expected_levels [$];
  int            mismatch_count = 0;
  int            results_seen   = 0;
  int            cycle_count    = 0;
  bit            send_burst     = 1'b0;

  function automatic level_result_t predict_level(input logic [SAMPLE_W-1:0] hand,
                                                  input logic [SAMPLE_W-1:0] foot);
    int unsigned   pick;
    int unsigned   avg;
    int unsigned   lvl;
    level_result_t res;
    pick = level_cfg.use_hand_channel ? hand : foot;
    hist_sum = hist_sum - sample_hist[hist_slot] + pick;
    sample_hist[hist_slot] = pick;
    hist_slot = (hist_slot + 1) % AVG_DEPTH_DEF;
    avg = hist_sum / AVG_DEPTH_DEF;
    lvl = avg / LEVEL_STEP;
    if (lvl >= TOP_LEVEL) begin
      lvl = TOP_LEVEL;
    end else if (avg - lvl * LEVEL_STEP > level_cfg.round_margin) begin
      lvl++;
    end
    if (lvl != last_raw) begin
      repeat_run = 0;
      last_raw = lvl;
    end else if (repeat_run < level_cfg.debounce_limit) begin
      repeat_run++;
    end else begin
      held_level = lvl;
    end
    res.average_value = SAMPLE_W'(avg);
    res.raw_level = LEVEL_W'(lvl);
    res.settled_level = LEVEL_W'(held_level);
    return res;
  endfunction

  function automatic logic [APB_ADDR_W-1:0] reg_addr(input reg_idx_t idx);
    return APB_ADDR_W'(idx) << 2;
  endfunction

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr[APB_ADDR_W-1:2])
      REG_USE_HAND:       level_cfg.use_hand_channel = data[0];
      REG_ROUND_MARGIN:   level_cfg.round_margin = data[MARGIN_W-1:0];
      REG_DEBOUNCE_LIMIT: level_cfg.debounce_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] hand,
                             input logic [SAMPLE_W-1:0] foot,
                             input logic typed,
                             input level_result_t typed_result);
    int            gap;
    level_result_t predicted;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.sample_hand <= hand;
    in_bus.sample_foot <= foot;
    do @(posedge clk); while (!in_bus.ready);
    predicted = predict_level(hand, foot);
    expected_levels.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count);
    shape_t              shape;
    int                  base;
    int                  left;
    int                  noise;
    logic [SAMPLE_W-1:0] pick;
    logic [SAMPLE_W-1:0] other;
    shape = SHAPE_NOISE;
    base = 0;
    left = 0;
    repeat (count) begin
      if (left == 0) begin
        case ($urandom_range(0, 9))
          0, 1:    shape = SHAPE_NOISE;
          2, 3, 4: shape = SHAPE_HOLD;
          5:       shape = SHAPE_RAIL;
          default: shape = SHAPE_EDGE;
        endcase
        left = $urandom_range(4, 40);
        case (shape)
          SHAPE_HOLD: base = $urandom_range(8, FULL_SCALE - 8);
          SHAPE_RAIL: base = $urandom_range(0, 1) ? FULL_SCALE : 0;
          SHAPE_EDGE: begin
            base = $urandom_range(0, LEVEL_COUNT_DEF) * LEVEL_STEP + $urandom_range(0, 47);
            if (base > FULL_SCALE) base = FULL_SCALE;
          end
          default: base = 0;
        endcase
      end
      left--;
      // steady stretches hold near one base value so the debounce can settle
      noise = $urandom_range(0, 15);
      case (shape)
        SHAPE_NOISE: pick = SAMPLE_W'($urandom_range(0, FULL_SCALE));
        SHAPE_HOLD:  pick = SAMPLE_W'(base + noise - 8);
        default:     pick = SAMPLE_W'(base);
      endcase
      other = SAMPLE_W'($urandom_range(0, FULL_SCALE));
      if (level_cfg.use_hand_channel) begin
        send_sample(pick, other, 1'b0, ZERO_RESULT);
      end else begin
        send_sample(other, pick, 1'b0, ZERO_RESULT);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : result_checker
    level_result_t want;
    level_result_t got;
    int            stall;
    bit            rx_burst;
    rx_burst = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      if (results_seen == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      got.average_value = out_bus.average_value;
      got.raw_level = out_bus.raw_level;
      got.settled_level = out_bus.settled_level;
      results_seen++;
      if (expected_levels.size() == 0) begin
        $display("%0t: transaction with nothing expected, actual avg %0d raw %0d stable %0d",
                 $time, got.average_value, got.raw_level, got.settled_level);
        mismatch_count++;
      end else begin
        want = expected_levels.pop_front();
        check_field("average_value", want.average_value, got.average_value);
        check_field("raw_level", want.raw_level, got.raw_level);
        check_field("settled_level", want.settled_level, got.settled_level);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    cfg_t phase_cfg;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample_hand = '0;
    in_bus.sample_foot = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    level_cfg = '{RST_USE_HAND, RST_MARGIN, RST_LIMIT};
    foreach (sample_hist[i]) sample_hist[i] = 0;
    hist_sum = 0;
    hist_slot = 0;
    last_raw = 0;
    repeat_run = 0;
    held_level = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_sample(DIRECTED[i].hand, DIRECTED[i].foot, DIRECTED[i].typed, DIRECTED[i].result);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      case (p)
        0:       phase_cfg = '{1'b1, 6'd0, 4'd0};
        1:       phase_cfg = '{1'b0, 6'd47, 4'd15};
        2:       phase_cfg = '{1'b1, 6'd47, 4'd0};
        3:       phase_cfg = '{1'b0, 6'd0, 4'd15};
        default: phase_cfg = '{1'($urandom_range(0, 1)), 6'($urandom_range(0, 47)),
                               4'($urandom_range(0, 15))};
      endcase
      // upper bits are noise and must be dropped
      apb_write(reg_addr(REG_USE_HAND), ($urandom << 1) | 32'(phase_cfg.use_hand_channel));
      apb_write(reg_addr(REG_ROUND_MARGIN), ($urandom << MARGIN_W) | 32'(phase_cfg.round_margin));
      apb_write(reg_addr(REG_DEBOUNCE_LIMIT),
                ($urandom << LIMIT_W) | 32'(phase_cfg.debounce_limit));
      apb_write(UNMAPPED_ADDR, $urandom);
      run_random_phase(PHASE_ITEMS);
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
